/* design/chained_hash_table_engine_core_macros.svh */
// Assertion macros used by the checker file.
`ifndef CHAINED_HASH_TABLE_ENGINE_CORE_MACROS_SVH
`define CHAINED_HASH_TABLE_ENGINE_CORE_MACROS_SVH

// Asserts an implication that is checked while reset is released.
`define CHT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Asserts an implication whose consequent is checked in the cycle after the antecedent.
`define CHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/cht_pkg.sv */
// ---------------------------------------------------------------------------
// cht_pkg
// Types, constants and helpers shared by the hash table engine modules.
// ---------------------------------------------------------------------------
package cht_pkg;

	localparam int Buckets = 157;
	localparam int Pool = 128;
	localparam int SlotW = $clog2(Pool);
	localparam int PtrW = SlotW + 1;
	localparam int BktW = $clog2(Buckets);
	localparam int CntW = 8;
	localparam int ModSteps = 3;

	// Weights of the upper key bytes modulo the bucket count.
	localparam int Fold8 = 256 % Buckets;
	localparam int Fold16 = 65536 % Buckets;
	localparam int Fold24 = (1 << 24) % Buckets;
	// Reciprocal of the bucket count, exact for folded values below 2**16.
	localparam int RecipShift = 24;
	localparam int RecipMagic = (1 << RecipShift) / Buckets + 1;

	typedef logic [PtrW-1:0] ptr_t;
	typedef logic [SlotW-1:0] slot_t;
	typedef logic [BktW-1:0] bkt_t;

	localparam ptr_t Nil = ptr_t'(Pool);

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_LOOKUP = 2'd2,
		ACT_CLEAR = 2'd3
	} act_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MOD,
		ST_CLR,
		ST_BKT_RD,
		ST_BKT_WAIT,
		ST_DISPATCH,
		ST_ADD_POP,
		ST_ADD_WAIT,
		ST_ADD_WR,
		ST_WALK_RD,
		ST_WALK_WAIT,
		ST_WALK_CHK,
		ST_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic mod_step;
		logic clr_step;
		logic clr_done_init;
		logic bkt_rd;
		logic pop_rd;
		logic add_write;
		logic walk_start;
		logic slot_rd;
		logic walk_adv;
		logic unlink;
		logic lookup_hit;
		logic emit;
		logic set_err;
	} cmd_t;

	// Status back from the datapath.
	typedef struct packed {
		logic mod_done;
		logic clr_last;
		logic bad_key;
		logic zero_val;
		logic pool_full;
		logic cur_nil;
		logic key_eq;
		logic val_eq;
		logic walk_over;
	} stat_t;

endpackage

/* design/cht_ctrl.sv */
// ---------------------------------------------------------------------------
// cht_ctrl
// Sequencer for add, remove, lookup and clear.
// ---------------------------------------------------------------------------
module cht_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input cht_pkg::act_t act,
	input cht_pkg::stat_t st,
	output logic busy,
	output cht_pkg::cmd_t cmd
);

	cht_pkg::state_t state_q, state_d;
	cht_pkg::act_t act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cht_pkg::ST_IDLE;
			act_q <= cht_pkg::ACT_ADD;
		end else begin
			state_q <= state_d;
			if (start && !busy) act_q <= act;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			cht_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					if (act == cht_pkg::ACT_CLEAR) begin
						cmd.clr_done_init = 1'b1;
						state_d = cht_pkg::ST_CLR;
					end else begin
						state_d = cht_pkg::ST_MOD;
					end
				end
			end
			cht_pkg::ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (st.mod_done) state_d = cht_pkg::ST_BKT_RD;
			end
			cht_pkg::ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) state_d = cht_pkg::ST_RESULT;
			end
			cht_pkg::ST_BKT_RD: begin
				cmd.bkt_rd = 1'b1;
				state_d = cht_pkg::ST_BKT_WAIT;
			end
			cht_pkg::ST_BKT_WAIT: state_d = cht_pkg::ST_DISPATCH;
			cht_pkg::ST_DISPATCH: begin
				if (st.bad_key || (act_q != cht_pkg::ACT_LOOKUP && st.zero_val)) begin
					cmd.set_err = 1'b1;
					state_d = cht_pkg::ST_RESULT;
				end else if (act_q == cht_pkg::ACT_ADD) begin
					if (st.pool_full) begin
						cmd.set_err = 1'b1;
						state_d = cht_pkg::ST_RESULT;
					end else begin
						cmd.pop_rd = 1'b1;
						state_d = cht_pkg::ST_ADD_WAIT;
					end
				end else begin
					cmd.walk_start = 1'b1;
					state_d = cht_pkg::ST_WALK_RD;
				end
			end
			cht_pkg::ST_ADD_POP: state_d = cht_pkg::ST_ADD_WAIT;
			cht_pkg::ST_ADD_WAIT: state_d = cht_pkg::ST_ADD_WR;
			cht_pkg::ST_ADD_WR: begin
				cmd.add_write = 1'b1;
				state_d = cht_pkg::ST_RESULT;
			end
			cht_pkg::ST_WALK_RD: begin
				if (st.cur_nil || st.walk_over) begin
					cmd.set_err = 1'b1;
					state_d = cht_pkg::ST_RESULT;
				end else begin
					cmd.slot_rd = 1'b1;
					state_d = cht_pkg::ST_WALK_WAIT;
				end
			end
			cht_pkg::ST_WALK_WAIT: state_d = cht_pkg::ST_WALK_CHK;
			cht_pkg::ST_WALK_CHK: begin
				if (act_q == cht_pkg::ACT_LOOKUP && st.key_eq) begin
					cmd.lookup_hit = 1'b1;
					state_d = cht_pkg::ST_RESULT;
				end else if (act_q == cht_pkg::ACT_REMOVE && st.key_eq && st.val_eq) begin
					cmd.unlink = 1'b1;
					state_d = cht_pkg::ST_RESULT;
				end else begin
					cmd.walk_adv = 1'b1;
					state_d = cht_pkg::ST_WALK_RD;
				end
			end
			cht_pkg::ST_RESULT: begin
				cmd.emit = 1'b1;
				state_d = cht_pkg::ST_IDLE;
			end
			default: state_d = cht_pkg::ST_IDLE;
		endcase
	end

endmodule

/* design/cht_dpath.sv */
// ---------------------------------------------------------------------------
// cht_dpath
// Slot memories, bucket tables, free stack, modulo unit and result register.
// ---------------------------------------------------------------------------
module cht_dpath (
	input logic clk,
	input logic arst_n,
	input logic signed [31:0] key,
	input logic [31:0] value,
	input cht_pkg::cmd_t cmd,
	output cht_pkg::stat_t st,
	output logic done,
	output logic status,
	output logic [31:0] found_value,
	output logic [7:0] entry_count
);

	// Memories without reset.
	logic [31:0] key_mem [cht_pkg::Pool];
	logic [31:0] val_mem [cht_pkg::Pool];
	cht_pkg::ptr_t next_mem [cht_pkg::Pool];
	cht_pkg::slot_t free_mem [cht_pkg::Pool];
	cht_pkg::ptr_t head_mem [cht_pkg::Buckets];
	cht_pkg::ptr_t tail_mem [cht_pkg::Buckets];

	// Valid bits for the bucket table stand in for its reset value.
	logic [cht_pkg::Buckets-1:0] bkt_vld_q;
	// Free stack entries below the fill mark hold their reset pattern.
	cht_pkg::ptr_t fill_q;
	cht_pkg::ptr_t top_q;
	logic [7:0] cnt_q;

	logic [31:0] key_q, val_q;
	logic [15:0] fold_q;
	logic [8:0] quo_q;
	cht_pkg::bkt_t rem_q;
	logic [5:0] step_q;
	cht_pkg::bkt_t bkt_q;
	cht_pkg::ptr_t head_rd, tail_rd;
	logic bvld_rd;
	cht_pkg::ptr_t cur_q, prev_q;
	logic [31:0] rk_q, rv_q;
	cht_pkg::ptr_t rn_q;
	cht_pkg::slot_t pop_q, pop_rd_q;
	logic pop_fill_q;
	logic [cht_pkg::PtrW:0] walk_q;
	logic err_q;
	logic [31:0] fv_q;

	cht_pkg::ptr_t head_eff, tail_eff;
	logic [15:0] fold_sum, quo_mul;
	logic [32:0] recip_prod;

	assign head_eff = bvld_rd ? head_rd : cht_pkg::Nil;
	assign tail_eff = bvld_rd ? tail_rd : cht_pkg::Nil;

	// Modulo in three stages: fold the key bytes with their weights, take the
	// quotient by a reciprocal multiply, then subtract quotient times buckets.
	assign fold_sum = {8'd0, key_q[31:24]} * 16'(cht_pkg::Fold24)
		+ {8'd0, key_q[23:16]} * 16'(cht_pkg::Fold16)
		+ {8'd0, key_q[15:8]} * 16'(cht_pkg::Fold8)
		+ {8'd0, key_q[7:0]};
	assign recip_prod = {17'd0, fold_q} * 33'(cht_pkg::RecipMagic);
	assign quo_mul = {7'd0, quo_q} * 16'(cht_pkg::Buckets);

	assign st.mod_done = step_q == 6'(cht_pkg::ModSteps - 1);
	assign st.clr_last = 1'b1;
	assign st.bad_key = key_q[31];
	assign st.zero_val = val_q == 32'd0;
	assign st.pool_full = top_q == '0;
	assign st.cur_nil = cur_q >= cht_pkg::Nil;
	assign st.key_eq = rk_q == key_q;
	assign st.val_eq = rv_q == val_q;
	assign st.walk_over = walk_q >= (cht_pkg::PtrW+1)'(cht_pkg::Pool);

	// Memory reads, registered.
	always_ff @(posedge clk) begin
		head_rd <= head_mem[bkt_q];
		tail_rd <= tail_mem[bkt_q];
		rk_q <= key_mem[cur_q[cht_pkg::SlotW-1:0]];
		rv_q <= val_mem[cur_q[cht_pkg::SlotW-1:0]];
		rn_q <= next_mem[cur_q[cht_pkg::SlotW-1:0]];
		pop_rd_q <= free_mem[top_q[cht_pkg::SlotW-1:0] - 1'b1];
	end

	// Memory writes.
	always_ff @(posedge clk) begin
		if (cmd.add_write) begin
			key_mem[pop_q] <= key_q;
			val_mem[pop_q] <= val_q;
			next_mem[pop_q] <= cht_pkg::Nil;
			tail_mem[bkt_q] <= cht_pkg::ptr_t'(pop_q);
			if (tail_eff >= cht_pkg::Nil) head_mem[bkt_q] <= cht_pkg::ptr_t'(pop_q);
			else head_mem[bkt_q] <= head_eff;
		end
		if (cmd.unlink) begin
			if (prev_q >= cht_pkg::Nil) head_mem[bkt_q] <= rn_q;
			else head_mem[bkt_q] <= head_eff;
			if (tail_eff == cur_q) tail_mem[bkt_q] <= prev_q;
			else tail_mem[bkt_q] <= tail_eff;
			if (top_q < cht_pkg::Nil) free_mem[top_q[cht_pkg::SlotW-1:0]] <= cur_q[cht_pkg::SlotW-1:0];
		end
		if (cmd.add_write && tail_eff < cht_pkg::Nil)
			next_mem[tail_eff[cht_pkg::SlotW-1:0]] <= cht_pkg::ptr_t'(pop_q);
		if (cmd.unlink && prev_q < cht_pkg::Nil)
			next_mem[prev_q[cht_pkg::SlotW-1:0]] <= rn_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key;
			val_q <= value;
		end
		fold_q <= fold_sum;
		quo_q <= recip_prod[cht_pkg::RecipShift+8:cht_pkg::RecipShift];
		rem_q <= cht_pkg::bkt_t'(fold_q - quo_mul);
		if (cmd.bkt_rd) bkt_q <= rem_q;
		if (cmd.walk_start) begin
			cur_q <= head_eff;
			prev_q <= cht_pkg::Nil;
		end
		if (cmd.walk_adv) begin
			prev_q <= cur_q;
			cur_q <= rn_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bkt_vld_q <= '0;
			fill_q <= cht_pkg::Nil;
			top_q <= cht_pkg::Nil;
			cnt_q <= '0;
			step_q <= '0;
			bvld_rd <= 1'b0;
			walk_q <= '0;
			err_q <= 1'b0;
			fv_q <= '0;
			pop_fill_q <= 1'b0;
			pop_q <= '0;
			done <= 1'b0;
			status <= 1'b0;
			found_value <= '0;
			entry_count <= '0;
		end else begin
			done <= cmd.emit;
			if (cmd.emit) begin
				status <= err_q;
				found_value <= fv_q;
				entry_count <= cnt_q;
			end
			if (cmd.load) begin
				step_q <= '0;
				err_q <= 1'b0;
				fv_q <= '0;
			end
			if (cmd.mod_step) step_q <= step_q + 6'd1;
			if (cmd.bkt_rd) bvld_rd <= bkt_vld_q[rem_q];
			if (cmd.clr_done_init) begin
				bkt_vld_q <= '0;
				fill_q <= cht_pkg::Nil;
				top_q <= cht_pkg::Nil;
				cnt_q <= '0;
			end
			if (cmd.set_err) err_q <= 1'b1;
			if (cmd.walk_start) walk_q <= '0;
			if (cmd.walk_adv) walk_q <= walk_q + 1'b1;
			if (cmd.pop_rd) pop_fill_q <= (top_q - 1'b1) < fill_q;
			if (cmd.pop_rd) top_q <= top_q - 1'b1;
			// The pop slot is taken from top_q after it was decremented.
			if (pop_fill_q) pop_q <= cht_pkg::slot_t'(cht_pkg::Pool - 1) - top_q[cht_pkg::SlotW-1:0];
			else pop_q <= pop_rd_q;
			if (cmd.add_write) begin
				bkt_vld_q[bkt_q] <= 1'b1;
				cnt_q <= cnt_q + 8'd1;
			end
			if (cmd.lookup_hit) fv_q <= rv_q;
			if (cmd.unlink) begin
				bkt_vld_q[bkt_q] <= 1'b1;
				if (top_q < cht_pkg::Nil) begin
					top_q <= top_q + 1'b1;
					if (top_q < fill_q) fill_q <= top_q;
				end
				if (cnt_q != 8'd0) cnt_q <= cnt_q - 8'd1;
			end
		end
	end

endmodule

/* design/chained_hash_table_engine_core.sv */
// ---------------------------------------------------------------------------
// chained_hash_table_engine_core
// Hash table with separate chaining over a pool of slots and a free stack.
// ---------------------------------------------------------------------------
// A request is taken on a rising edge where start is high and busy is low;
// action, key and value are sampled then. busy stays high until the result
// is shown: done pulses for one cycle with status, found_value and
// entry_count, and the receiver must take it in that cycle.
// A non-clear request first reduces the key modulo the bucket count (byte
// fold, reciprocal multiply, subtract), then reads the bucket table and
// dispatches. Add pops a free slot and links it. A rejected request (negative
// key, zero value on add or remove, full pool on add) goes from dispatch
// straight to the result. Remove and lookup walk the chain one slot at a time
// over the single slot memory read port. Clear clears the bucket valid bits
// and the free stack fill mark at once. busy is low while done is shown, so
// the next request can be taken at the end of that cycle.
// Reset empties all buckets, fills the free stack and zeroes the count.
// Slot memories have no reset; they are written when they are linked.
// ---------------------------------------------------------------------------
module chained_hash_table_engine_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] action,
	input logic signed [31:0] key,
	input logic [31:0] value,
	output logic done,
	output logic status,
	output logic [31:0] found_value,
	output logic [7:0] entry_count
);

	cht_pkg::cmd_t cmd;
	cht_pkg::stat_t st;

	// Controller sequences each request.
	cht_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.act(cht_pkg::act_t'(action)),
		.st(st),
		.busy(busy),
		.cmd(cmd)
	);

	// Datapath holds all table state.
	cht_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.key(key),
		.value(value),
		.cmd(cmd),
		.st(st),
		.done(done),
		.status(status),
		.found_value(found_value),
		.entry_count(entry_count)
	);

endmodule

/* design/cht_checker.sv */
// ---------------------------------------------------------------------------
// cht_checker
// Port level checks of the hash table engine.
// ---------------------------------------------------------------------------
`include "chained_hash_table_engine_core_macros.svh"

module cht_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic status,
	input logic [31:0] found_value,
	input logic [7:0] entry_count
);

	`CHT_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "no busy after request")
	`CHT_ASSERT_NEXT(a_done_frees, clk, arst_n, done, !done, "done longer than one cycle")
	`CHT_ASSERT_IMPL(a_err_zero, clk, arst_n, done && status, found_value == 32'd0, "error with value")
	`CHT_ASSERT_IMPL(a_count_max, clk, arst_n, done, entry_count <= 8'd128, "count too large")

endmodule

bind chained_hash_table_engine_core cht_checker u_cht_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.status(status),
	.found_value(found_value),
	.entry_count(entry_count)
);

/* tb/tb_chained_hash_table_engine_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_chained_hash_table_engine_core
// Self-checking bench for the chained hash table engine.
// ---------------------------------------------------------------------------
// Requests go in through the start/busy handshake and every done pulse is
// compared field by field with an expected response. The bench keeps its own
// image of the table: chains and the live count. Directed rows cover
// rejects, an empty table, chains and clear, then the pool is filled to the
// brim. A random phase follows, with keys mostly drawn from a small set so
// that chains grow long and removes and lookups hit often.
// ---------------------------------------------------------------------------
module tb_chained_hash_table_engine_core;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] action;
	logic signed [31:0] key;
	logic [31:0] value;
	logic done;
	logic status;
	logic [31:0] found_value;
	logic [7:0] entry_count;

	chained_hash_table_engine_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .key(key), .value(value), .done(done),
		.status(status), .found_value(found_value), .entry_count(entry_count)
	);

	typedef struct packed {
		logic status;
		logic [31:0] found;
		logic [7:0] count;
	} resp_t;

	// A directed row: request, and optionally a typed-in response.
	typedef struct {
		cht_pkg::act_t act;
		logic [31:0] k;
		logic [31:0] v;
		bit typed;
		resp_t r;
	} row_t;

	// Table image. Each bucket chain is held oldest first.
	logic [31:0] chain_key[cht_pkg::Buckets][$];
	logic [31:0] chain_val[cht_pkg::Buckets][$];
	int unsigned live_entries;

	resp_t pending_resp[$];
	int errors = 0;
	int responses_seen = 0;
	int hits_seen = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Timeout at %0t", $time);
		$display("Test completed with failures");
		$finish;
	end

	function automatic resp_t table_apply(cht_pkg::act_t a, logic [31:0] k,
			logic [31:0] v);
		resp_t r;
		int b;
		r.status = 1'b1;
		r.found = '0;
		if (a == cht_pkg::ACT_CLEAR) begin
			for (int i = 0; i < cht_pkg::Buckets; i++) begin
				chain_key[i].delete();
				chain_val[i].delete();
			end
			live_entries = 0;
			r.status = 1'b0;
		end else if (!k[31]) begin
			b = k % cht_pkg::Buckets;
			case (a)
				cht_pkg::ACT_ADD: if (v != 0 && live_entries < cht_pkg::Pool) begin
					chain_key[b].push_back(k);
					chain_val[b].push_back(v);
					live_entries++;
					r.status = 1'b0;
				end
				cht_pkg::ACT_REMOVE: if (v != 0) begin
					foreach (chain_key[b][i])
						if (r.status && chain_key[b][i] == k && chain_val[b][i] == v) begin
							chain_key[b].delete(i);
							chain_val[b].delete(i);
							live_entries--;
							r.status = 1'b0;
						end
				end
				default: foreach (chain_key[b][i])
					if (r.status && chain_key[b][i] == k) begin
						r.found = chain_val[b][i];
						r.status = 1'b0;
					end
			endcase
		end
		r.count = live_entries[7:0];
		return r;
	endfunction

	// Drive one request and wait for it to be taken. Idle cycles may come first.
	// start stays high after the request is taken; the caller drops it
	// before waiting with no request to send.
	task automatic issue(cht_pkg::act_t a, logic [31:0] k, logic [31:0] v,
			bit may_idle, bit typed, resp_t want);
		resp_t r;
		while (may_idle && $urandom_range(99) < 12) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		action <= a;
		key <= k;
		value <= v;
		do @(posedge clk); while (busy);
		r = table_apply(a, k, v);
		if (typed && r != want) begin
			$display("%0t: directed row exp %0b/%h/%0d predicted %0b/%h/%0d", $time,
				want.status, want.found, want.count, r.status, r.found, r.count);
			errors++;
		end
		pending_resp.push_back(typed ? want : r);
	endtask

	// Response checker: done cannot be held off, so sample every edge.
	always @(posedge clk) begin
		resp_t w;
		if (arst_n && done) begin
			responses_seen++;
			if (pending_resp.size() == 0) begin
				$display("%0t: unexpected response status=%0b", $time, status);
				errors++;
			end else begin
				w = pending_resp.pop_front();
				if (status !== w.status) begin
					$display("%0t: status exp %0b got %0b", $time, w.status, status);
					errors++;
				end
				if (found_value !== w.found) begin
					$display("%0t: found_value exp %h got %h", $time, w.found,
						found_value);
					errors++;
				end
				if (entry_count !== w.count) begin
					$display("%0t: entry_count exp %0d got %0d", $time, w.count,
						entry_count);
					errors++;
				end
				if (w.status == 1'b0 && w.found != 0)
					hits_seen++;
			end
		end
	end

	function automatic row_t mk(cht_pkg::act_t a, logic [31:0] k, logic [31:0] v,
			bit t, logic s, logic [31:0] f, logic [7:0] c);
		row_t r;
		r.act = a;
		r.k = k;
		r.v = v;
		r.typed = t;
		r.r.status = s;
		r.r.found = f;
		r.r.count = c;
		return r;
	endfunction

	initial begin
		row_t rows[$];
		resp_t none;
		cht_pkg::act_t a;
		logic [31:0] k, v;
		int pick;
		none = '{1'b0, 32'h0, 8'h0};
		start = 1'b0;
		action = cht_pkg::ACT_ADD;
		key = '0;
		value = '0;
		arst_n = 1'b0;
		for (int i = 0; i < cht_pkg::Buckets; i++) begin
			chain_key[i].delete();
			chain_val[i].delete();
		end
		live_entries = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Rejects on an empty table, then chains with same-bucket keys.
		rows.push_back(mk(cht_pkg::ACT_LOOKUP, 32'd5, 32'd0, 1, 1'b1, 0, 0));
		rows.push_back(mk(cht_pkg::ACT_REMOVE, 32'd5, 32'd1, 1, 1'b1, 0, 0));
		rows.push_back(mk(cht_pkg::ACT_ADD, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1'b1, 0, 0));
		rows.push_back(mk(cht_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'd1, 1, 1'b1, 0, 0));
		rows.push_back(mk(cht_pkg::ACT_ADD, 32'd7, 32'd0, 1, 1'b1, 0, 0));
		rows.push_back(mk(cht_pkg::ACT_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1'b0, 0, 1));
		rows.push_back(mk(cht_pkg::ACT_LOOKUP, 32'h7FFF_FFFF, 32'd0, 1, 1'b0,
			32'hFFFF_FFFF, 1));
		rows.push_back(mk(cht_pkg::ACT_ADD, 32'd0, 32'd10, 0, 0, 0, 0));
		rows.push_back(mk(cht_pkg::ACT_ADD, 32'd157, 32'd11, 0, 0, 0, 0));
		rows.push_back(mk(cht_pkg::ACT_ADD, 32'd0, 32'd12, 0, 0, 0, 0));
		rows.push_back(mk(cht_pkg::ACT_ADD, 32'd314, 32'd13, 0, 0, 0, 0));
		rows.push_back(mk(cht_pkg::ACT_LOOKUP, 32'd0, 32'd0, 0, 0, 0, 0));
		rows.push_back(mk(cht_pkg::ACT_REMOVE, 32'd0, 32'd12, 0, 0, 0, 0));
		rows.push_back(mk(cht_pkg::ACT_REMOVE, 32'd0, 32'd12, 0, 0, 0, 0));
		rows.push_back(mk(cht_pkg::ACT_REMOVE, 32'd0, 32'd10, 0, 0, 0, 0));
		rows.push_back(mk(cht_pkg::ACT_LOOKUP, 32'd314, 32'hFFFF_FFFF, 0, 0, 0, 0));
		rows.push_back(mk(cht_pkg::ACT_LOOKUP, 32'h8000_0001, 32'd1, 1, 1'b1, 0, 3));
		rows.push_back(mk(cht_pkg::ACT_REMOVE, 32'd157, 32'd0, 1, 1'b1, 0, 3));
		rows.push_back(mk(cht_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b0,
			0, 0));
		rows.push_back(mk(cht_pkg::ACT_LOOKUP, 32'd314, 32'd0, 1, 1'b1, 0, 0));
		foreach (rows[i])
			issue(rows[i].act, rows[i].k, rows[i].v, 1'b0, rows[i].typed, rows[i].r);

		// Fill the pool to the brim, then one add past it.
		for (int i = 0; i < cht_pkg::Pool; i++)
			issue(cht_pkg::ACT_ADD, $urandom_range(400), $urandom_range(32'hFFFF, 1),
				1'b1, 0, none);
		issue(cht_pkg::ACT_ADD, 32'd3, 32'd3, 1'b0, 1'b1, '{1'b1, 32'h0, 8'd128});

		// The sender holds off until every pending response has come back.
		start <= 1'b0;
		while (pending_resp.size() != 0)
			@(posedge clk);

		// Random phase; items 200..349 are issued back to back.
		for (int n = 0; n < 600; n++) begin
			pick = $urandom_range(99);
			if (pick < 40) a = cht_pkg::ACT_ADD;
			else if (pick < 65) a = cht_pkg::ACT_REMOVE;
			else if (pick < 98) a = cht_pkg::ACT_LOOKUP;
			else a = cht_pkg::ACT_CLEAR;
			pick = $urandom_range(99);
			if (pick < 80) k = $urandom_range(40) * ($urandom_range(1) ? 157 : 1);
			else k = $urandom;
			v = ($urandom_range(99) < 75) ? $urandom_range(6) : $urandom;
			// Removes often name an entry that really is there.
			if (a == cht_pkg::ACT_REMOVE && !k[31]
					&& chain_key[k % cht_pkg::Buckets].size() != 0
					&& $urandom_range(1)) begin
				pick = $urandom_range(chain_key[k % cht_pkg::Buckets].size() - 1);
				v = chain_val[k % cht_pkg::Buckets][pick];
				k = chain_key[k % cht_pkg::Buckets][pick];
			end
			issue(a, k, v, !(n >= 200 && n < 350), 0, none);
		end

		start <= 1'b0;
		while (pending_resp.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("Checked %0d responses, %0d of them lookup hits, with %0d live at end.",
			responses_seen, hits_seen, live_entries);
		if (errors == 0 && pending_resp.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/cht_pkg.sv
design/cht_ctrl.sv
design/cht_dpath.sv
design/chained_hash_table_engine_core.sv
design/cht_checker.sv
tb/tb_chained_hash_table_engine_core.sv
